### rtl/core/lattice_d2q5_cell_collision_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the D2Q5 cell collision block
// Clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef LATTICE_D2Q5_CELL_COLLISION_ASSERT_SVH
`define LATTICE_D2Q5_CELL_COLLISION_ASSERT_SVH

// Same-cycle implication.
`define LDC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ldc_pkg.sv
// ----------------------------------------------------------------------------
// ldc_pkg
// Types, constants and arithmetic helpers shared by the D2Q5 collision block.
// ----------------------------------------------------------------------------
`default_nettype none

package ldc_pkg;

    // Lattice size
    localparam int GRID_W = 512;
    localparam int GRID_H = 64;

    // Depth of the queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int S_DATA_W = 176;
    localparam int M_DATA_W = 160;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 18;

    typedef logic signed [31:0] q16_t;
    typedef logic signed [15:0] coord_t;

    localparam coord_t GRID_MID    = 16'(GRID_H / 2);
    localparam coord_t EDGE_COL_LO = 16'sd1;
    localparam coord_t EDGE_COL_HI = 16'(GRID_W - 1);
    localparam coord_t EDGE_ROW_LO = 16'sd1;
    localparam coord_t EDGE_ROW_HI = 16'(GRID_H - 2);

    // Arithmetic constants
    localparam logic [19:0]        RECIP3     = 20'd349525;      // (2^20 - 1) / 3
    localparam logic [15:0]        DIV3_HI    = 16'd43690;       // (2^17 - 2) / 3
    localparam logic signed [49:0] FEQ_BIAS   = 50'sd196608;     // 3 * 2^16
    localparam logic signed [34:0] U_OFFSET   = 35'sd6442450944; // 3 * 2^31
    localparam logic signed [34:0] D_OFFSET   = 35'sd2147483648; // 2^31
    localparam logic signed [18:0] Q_ONE      = 19'sd65536;

    // Reset values of the configuration registers
    localparam logic [17:0] RST_RELAX_RATE  = 18'd131072;
    localparam logic [16:0] RST_SPEED_TERM  = 17'd49152;
    localparam logic [16:0] RST_FLUTE_GAIN  = 17'd65536;
    localparam logic [16:0] RST_EDGE_GAIN   = 17'd0;
    localparam logic [8:0]  RST_FLUTE_START = 9'd20;
    localparam logic [8:0]  RST_FLUTE_LEN   = 9'd330;
    localparam logic [4:0]  RST_FLUTE_HH    = 5'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RELAX_RATE,
        CFG_SPEED_TERM,
        CFG_FLUTE_GAIN,
        CFG_EDGE_GAIN,
        CFG_FLUTE_START_X,
        CFG_FLUTE_LENGTH,
        CFG_FLUTE_HALF_HEIGHT
    } cfg_index_t;

    // How a direction pair is updated
    typedef enum logic [1:0] {
        PM_RELAX,
        PM_FLUTE,
        PM_EDGE
    } pair_mode_t;

    typedef struct packed {
        logic [17:0] relax_rate;
        logic [16:0] speed_term;
        logic [16:0] flute_gain;
        logic [16:0] edge_gain;
        logic [8:0]  flute_start_x;
        logic [8:0]  flute_length;
        logic [4:0]  flute_half_height;
    } cfg_t;

    // Classified cell passed from front to back
    typedef struct packed {
        q16_t       f_rest;
        q16_t       f_east;
        q16_t       f_north;
        q16_t       f_west;
        q16_t       f_south;
        q16_t       rho;
        q16_t       jx;
        q16_t       jy;
        pair_mode_t x_mode;
        pair_mode_t y_mode;
    } cell_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic pop;
        logic tail_valid;
    } back_stat_t;

    function automatic q16_t sat32(input logic signed [63:0] v);
        q16_t r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // floor(v / 3) for v below 2^20: reciprocal multiply, one correction
    function automatic logic [19:0] div3(input logic [19:0] v);
        logic [39:0] prod;
        logic [19:0] q;
        logic [21:0] rem;
        prod = 40'(v) * 40'(RECIP3);
        q    = prod[39:20];
        rem  = 22'(v) - 22'(q) * 22'd3;
        if (rem >= 22'd3) begin
            q = q + 20'd1;
        end
        return q;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ldc_front.sv
// ----------------------------------------------------------------------------
// ldc_front
// Accept cells, form density and momenta, classify the wall cases.
// ----------------------------------------------------------------------------
`default_nettype none

module ldc_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire ldc_pkg::cfg_t                  cfg,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [ldc_pkg::S_DATA_W-1:0]   s_data,
    input  wire ldc_pkg::q_status_t             q_status,
    output logic                                push,
    output ldc_pkg::cell_t                      push_data
);

    logic                 valid_reg;
    ldc_pkg::cell_t       item_reg;
    ldc_pkg::cell_t       item_next;

    logic [8:0]           cell_x;
    logic [5:0]           cell_y;
    ldc_pkg::q16_t        f0, fe, fn, fw, fs;
    logic signed [34:0]   sum;
    ldc_pkg::coord_t      x16, y16, lo16, hi16, fsx16, fend16;
    logic                 in_band, on_wall_col, on_edge_col, on_wall_row, in_len, on_edge_row;

    assign cell_x = s_data[8:0];
    assign cell_y = s_data[14:9];
    assign f0     = s_data[46:15];
    assign fe     = s_data[78:47];
    assign fn     = s_data[110:79];
    assign fw     = s_data[142:111];
    assign fs     = s_data[174:143];

    always_comb begin
        sum = 35'(f0) + 35'(fe) + 35'(fn) + 35'(fw) + 35'(fs);

        x16    = $signed({7'b0, cell_x});
        y16    = $signed({10'b0, cell_y});
        lo16   = ldc_pkg::GRID_MID - $signed({11'b0, cfg.flute_half_height});
        hi16   = ldc_pkg::GRID_MID + $signed({11'b0, cfg.flute_half_height});
        fsx16  = $signed({7'b0, cfg.flute_start_x});
        fend16 = fsx16 + $signed({7'b0, cfg.flute_length});

        in_band     = (y16 >= lo16) && (y16 <= hi16);
        on_wall_col = (x16 == fsx16) && in_band;
        on_edge_col = (x16 == ldc_pkg::EDGE_COL_LO) || (x16 == ldc_pkg::EDGE_COL_HI);
        on_wall_row = (y16 == lo16) || (y16 == hi16);
        in_len      = (x16 >= fsx16) && (x16 <= fend16);
        on_edge_row = (y16 == ldc_pkg::EDGE_ROW_LO) || (y16 == ldc_pkg::EDGE_ROW_HI);

        item_next.f_rest  = f0;
        item_next.f_east  = fe;
        item_next.f_north = fn;
        item_next.f_west  = fw;
        item_next.f_south = fs;
        item_next.rho     = ldc_pkg::sat32(64'(sum));
        item_next.jx      = ldc_pkg::sat32(64'(33'(fe) - 33'(fw)));
        item_next.jy      = ldc_pkg::sat32(64'(33'(fn) - 33'(fs)));

        if (on_wall_col) begin
            item_next.x_mode = ldc_pkg::PM_FLUTE;
        end else if (on_edge_col) begin
            item_next.x_mode = ldc_pkg::PM_EDGE;
        end else begin
            item_next.x_mode = ldc_pkg::PM_RELAX;
        end

        if (on_wall_row && in_len) begin
            item_next.y_mode = ldc_pkg::PM_FLUTE;
        end else if (on_edge_row) begin
            item_next.y_mode = ldc_pkg::PM_EDGE;
        end else begin
            item_next.y_mode = ldc_pkg::PM_RELAX;
        end
    end

    // Hold the item while the queue is full
    assign s_ready   = !valid_reg || !q_status.full;
    assign push      = valid_reg && !q_status.full;
    assign push_data = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ldc_queue.sv
// ----------------------------------------------------------------------------
// ldc_queue
// Short register queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
`default_nettype none

module ldc_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire ldc_pkg::cell_t         push_data,
    input  wire logic                   pop,
    output ldc_pkg::cell_t              head,
    output ldc_pkg::q_status_t          status
);

    ldc_pkg::cell_t                     entry_reg [ldc_pkg::QDEPTH];
    logic [ldc_pkg::QPTR_W-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [ldc_pkg::QCNT_W-1:0]         count_reg;

    function automatic logic [ldc_pkg::QPTR_W-1:0] bump(
        input logic [ldc_pkg::QPTR_W-1:0] p
    );
        logic [ldc_pkg::QPTR_W-1:0] r;
        if (p == ldc_pkg::QPTR_W'(ldc_pkg::QDEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == ldc_pkg::QCNT_W'(ldc_pkg::QDEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ldc_back.sv
// ----------------------------------------------------------------------------
// ldc_back
// Equilibrium, relaxation and bounce-back gain, six register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ldc_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire ldc_pkg::cfg_t                  cfg,
    input  wire ldc_pkg::cell_t                 head,
    input  wire ldc_pkg::q_status_t             q_status,
    output ldc_pkg::back_stat_t                 stat,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [ldc_pkg::M_DATA_W-1:0]        m_data
);

    // Moving lanes: 0 east, 1 north, 2 west, 3 south; lane m+2 opposes lane m.
    localparam int NL = 4;

    logic                   en, pop;
    logic signed [17:0]     aux_reg;
    logic [19:0]            aux_q;

    // Stage 1 inputs
    ldc_pkg::q16_t          fm_in  [NL];
    logic signed [32:0]     jl_in  [NL];
    ldc_pkg::pair_mode_t    mode_in [NL];
    logic                   bnc_in [NL];
    logic [16:0]            g_in   [NL];
    logic signed [49:0]     gp_in  [NL];

    // Stage 1
    logic                   v1_reg;
    ldc_pkg::q16_t          frest1_reg;
    ldc_pkg::q16_t          fm1_reg [NL];
    logic signed [32:0]     jl1_reg [NL];
    logic                   bnc1_reg [NL];
    logic signed [49:0]     gp1_reg [NL];
    logic signed [49:0]     p0_1_reg, sr1_reg;

    // Stage 2
    logic                   v2_reg;
    ldc_pkg::q16_t          frest2_reg;
    ldc_pkg::q16_t          fm2_reg [NL];
    logic signed [32:0]     jl2_reg [NL];
    logic                   bnc2_reg [NL];
    ldc_pkg::q16_t          gain2_reg [NL];
    ldc_pkg::q16_t          feq0_2_reg;
    logic [33:0]            u2_reg [2];
    logic signed [49:0]     tsum [2];
    logic signed [32:0]     t_ax [2];

    // Stage 3
    logic                   v3_reg;
    ldc_pkg::q16_t          frest3_reg;
    ldc_pkg::q16_t          fm3_reg [NL];
    logic signed [32:0]     jl3_reg [NL];
    logic                   bnc3_reg [NL];
    ldc_pkg::q16_t          gain3_reg [NL];
    logic signed [32:0]     diff0_3_reg;
    logic [32:0]            hi3_reg [2];
    logic [19:0]            lo3_reg [2];

    // Stage 4
    logic                   v4_reg;
    ldc_pkg::q16_t          frest4_reg;
    ldc_pkg::q16_t          fm4_reg [NL];
    logic                   bnc4_reg [NL];
    ldc_pkg::q16_t          gain4_reg [NL];
    logic signed [32:0]     diff0_4_reg;
    logic signed [32:0]     diff4_reg [NL];
    logic [33:0]            quot [2];
    logic signed [34:0]     d_ax [2];
    logic signed [34:0]     mhalf [NL];
    ldc_pkg::q16_t          feq_m [NL];

    // Stage 5
    logic                   v5_reg;
    ldc_pkg::q16_t          frest5_reg;
    ldc_pkg::q16_t          fm5_reg [NL];
    logic                   bnc5_reg [NL];
    ldc_pkg::q16_t          gain5_reg [NL];
    logic signed [51:0]     prod0_5_reg;
    logic signed [51:0]     prod5_reg [NL];

    // Output register
    logic                   m_valid_reg;
    ldc_pkg::q16_t          out_rest_reg;
    ldc_pkg::q16_t          out_m_reg [NL];
    ldc_pkg::q16_t          out_m_next [NL];
    ldc_pkg::q16_t          out_rest_next;

    assign en       = !m_valid_reg || m_ready;
    assign pop      = en && !q_status.empty;
    assign stat.pop = pop;
    assign stat.tail_valid = v5_reg;
    assign m_valid  = m_valid_reg;
    assign m_data   = {out_m_reg[3], out_m_reg[2], out_m_reg[1], out_m_reg[0], out_rest_reg};

    // Rest-weight factor 1 - 2s/3, from the speed register
    assign aux_q = ldc_pkg::div3(20'({cfg.speed_term, 1'b0}) + 20'd1);

    always_ff @(posedge aclk) begin
        aux_reg <= 18'(ldc_pkg::Q_ONE - $signed({2'b0, aux_q[16:0]}));
    end

    always_comb begin
        fm_in[0]   = head.f_east;
        fm_in[1]   = head.f_north;
        fm_in[2]   = head.f_west;
        fm_in[3]   = head.f_south;
        jl_in[0]   = 33'($signed(head.jx));
        jl_in[1]   = 33'($signed(head.jy));
        jl_in[2]   = -33'($signed(head.jx));
        jl_in[3]   = -33'($signed(head.jy));
        mode_in[0] = head.x_mode;
        mode_in[1] = head.y_mode;
        mode_in[2] = head.x_mode;
        mode_in[3] = head.y_mode;
        for (int m = 0; m < NL; m++) begin
            bnc_in[m] = (mode_in[m] != ldc_pkg::PM_RELAX);
            g_in[m]   = (mode_in[m] == ldc_pkg::PM_FLUTE) ? cfg.flute_gain : cfg.edge_gain;
            gp_in[m]  = 50'($signed({1'b0, g_in[m]})) * 50'(fm_in[(m + 2) % NL]);
        end
    end

    // Equilibrium of a moving lane: floor((s*rho + 3*2^16*(j+1)) / (6*2^16)).
    // Split j+1 into its half and parity; the parity part leaves sr + bias,
    // which is shifted by 17 and divided by 3 in two narrow halves.
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            tsum[a] = sr1_reg + (jl1_reg[a][0] ? 50'sd0 : ldc_pkg::FEQ_BIAS);
            t_ax[a] = 33'(tsum[a] >>> 17);
        end
        for (int a = 0; a < 2; a++) begin
            quot[a] = 34'(hi3_reg[a]) + 34'(lo3_reg[a]);
            d_ax[a] = $signed({1'b0, quot[a]}) - ldc_pkg::D_OFFSET;
        end
        for (int m = 0; m < NL; m++) begin
            mhalf[m] = (35'(jl3_reg[m]) + 35'sd1) >>> 1;
            feq_m[m] = ldc_pkg::sat32(64'(d_ax[m % 2] + mhalf[m]));
        end
        out_rest_next = ldc_pkg::sat32(64'(53'(frest5_reg)
                        + 53'((prod0_5_reg + 52'sd32768) >>> 16)));
        for (int m = 0; m < NL; m++) begin
            out_m_next[m] = bnc5_reg[m] ? gain5_reg[m]
                          : ldc_pkg::sat32(64'(53'(fm5_reg[m])
                            + 53'((prod5_reg[m] + 52'sd32768) >>> 16)));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= pop;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            m_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1: products of density and gains
            frest1_reg <= head.f_rest;
            p0_1_reg   <= 50'($signed(head.rho)) * 50'(aux_reg);
            sr1_reg    <= 50'($signed({1'b0, cfg.speed_term})) * 50'($signed(head.rho));
            for (int m = 0; m < NL; m++) begin
                fm1_reg[m]  <= fm_in[m];
                jl1_reg[m]  <= jl_in[m];
                bnc1_reg[m] <= bnc_in[m];
                gp1_reg[m]  <= gp_in[m];
            end

            // stage 2: round, offset for the divide by three
            frest2_reg <= frest1_reg;
            feq0_2_reg <= ldc_pkg::sat32(64'((p0_1_reg + 50'sd32768) >>> 16));
            for (int a = 0; a < 2; a++) begin
                u2_reg[a] <= 34'(35'(t_ax[a]) + ldc_pkg::U_OFFSET);
            end
            for (int m = 0; m < NL; m++) begin
                fm2_reg[m]   <= fm1_reg[m];
                jl2_reg[m]   <= jl1_reg[m];
                bnc2_reg[m]  <= bnc1_reg[m];
                gain2_reg[m] <= ldc_pkg::sat32(64'((gp1_reg[m] + 50'sd32768) >>> 16));
            end

            // stage 3: divide by three in high and low halves
            frest3_reg  <= frest2_reg;
            diff0_3_reg <= 33'(feq0_2_reg) - 33'(frest2_reg);
            for (int a = 0; a < 2; a++) begin
                hi3_reg[a] <= 33'(u2_reg[a][33:17]) * 33'(ldc_pkg::DIV3_HI);
                lo3_reg[a] <= ldc_pkg::div3(20'({u2_reg[a][33:17], 1'b0})
                                            + 20'(u2_reg[a][16:0]));
            end
            for (int m = 0; m < NL; m++) begin
                fm3_reg[m]   <= fm2_reg[m];
                jl3_reg[m]   <= jl2_reg[m];
                bnc3_reg[m]  <= bnc2_reg[m];
                gain3_reg[m] <= gain2_reg[m];
            end

            // stage 4: equilibrium and its distance from each distribution
            frest4_reg  <= frest3_reg;
            diff0_4_reg <= diff0_3_reg;
            for (int m = 0; m < NL; m++) begin
                fm4_reg[m]   <= fm3_reg[m];
                bnc4_reg[m]  <= bnc3_reg[m];
                gain4_reg[m] <= gain3_reg[m];
                diff4_reg[m] <= 33'(feq_m[m]) - 33'(fm3_reg[m]);
            end

            // stage 5: scale by the relaxation rate
            frest5_reg  <= frest4_reg;
            prod0_5_reg <= 52'($signed({1'b0, cfg.relax_rate})) * 52'(diff0_4_reg);
            for (int m = 0; m < NL; m++) begin
                fm5_reg[m]   <= fm4_reg[m];
                bnc5_reg[m]  <= bnc4_reg[m];
                gain5_reg[m] <= gain4_reg[m];
                prod5_reg[m] <= 52'($signed({1'b0, cfg.relax_rate})) * 52'(diff4_reg[m]);
            end

            // output: relaxed value or bounce-back swap
            out_rest_reg <= out_rest_next;
            for (int m = 0; m < NL; m++) begin
                out_m_reg[m] <= out_m_next[m];
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/lattice_d2q5_cell_collision.sv
// ----------------------------------------------------------------------------
// lattice_d2q5_cell_collision
// D2Q5 BGK collision of one lattice cell with flute-wall and edge bounce-back.
// ----------------------------------------------------------------------------
//
//  channel   direction  width  contents
//  s_axis    in         176    cell_x, cell_y, dist_rest/east/north/west/south
//  m_axis    out        160    new_rest, new_east, new_north, new_west, new_south
//  cfg       in         3+18   register index and write data, write only
//
//  One item per clock sustained while m_axis is not stalled; each item
//  passes through the front register, a queue slot and six back stages.
//  Reset clears every valid flag and loads the register defaults; no sweep.
//  A stall on m_axis freezes the back stages; the four-entry queue and the
//  front register absorb items until both are full, then s_axis_tready drops.
//
`default_nettype none

`include "lattice_d2q5_cell_collision_assert.svh"

module lattice_d2q5_cell_collision (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    // Cell in
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [8:0] cell_x, [14:9] cell_y, [46:15] dist_rest, [78:47] dist_east,
    // [110:79] dist_north, [142:111] dist_west, [174:143] dist_south, [175] zero
    input  wire logic [ldc_pkg::S_DATA_W-1:0]       s_axis_tdata,

    // Relaxed cell out
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [31:0] new_rest, [63:32] new_east, [95:64] new_north,
    // [127:96] new_west, [159:128] new_south
    output logic [ldc_pkg::M_DATA_W-1:0]            m_axis_tdata,

    // Register writes
    input  wire logic                               cfg_wr_en,
    input  wire logic [ldc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ldc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    ldc_pkg::cfg_t          cfg_reg;
    ldc_pkg::q_status_t     q_stat;
    ldc_pkg::back_stat_t    back_stat;
    ldc_pkg::cell_t         front_data;
    ldc_pkg::cell_t         q_head;
    logic                   front_push;

    // Register file: take the low bits of the write data for each register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.relax_rate        <= ldc_pkg::RST_RELAX_RATE;
            cfg_reg.speed_term        <= ldc_pkg::RST_SPEED_TERM;
            cfg_reg.flute_gain        <= ldc_pkg::RST_FLUTE_GAIN;
            cfg_reg.edge_gain         <= ldc_pkg::RST_EDGE_GAIN;
            cfg_reg.flute_start_x     <= ldc_pkg::RST_FLUTE_START;
            cfg_reg.flute_length      <= ldc_pkg::RST_FLUTE_LEN;
            cfg_reg.flute_half_height <= ldc_pkg::RST_FLUTE_HH;
        end else if (cfg_wr_en) begin
            case (ldc_pkg::cfg_index_t'(cfg_index))
                ldc_pkg::CFG_RELAX_RATE: begin
                    cfg_reg.relax_rate <= cfg_wdata[17:0];
                end
                ldc_pkg::CFG_SPEED_TERM: begin
                    cfg_reg.speed_term <= cfg_wdata[16:0];
                end
                ldc_pkg::CFG_FLUTE_GAIN: begin
                    cfg_reg.flute_gain <= cfg_wdata[16:0];
                end
                ldc_pkg::CFG_EDGE_GAIN: begin
                    cfg_reg.edge_gain <= cfg_wdata[16:0];
                end
                ldc_pkg::CFG_FLUTE_START_X: begin
                    cfg_reg.flute_start_x <= cfg_wdata[8:0];
                end
                ldc_pkg::CFG_FLUTE_LENGTH: begin
                    cfg_reg.flute_length <= cfg_wdata[8:0];
                end
                ldc_pkg::CFG_FLUTE_HALF_HEIGHT: begin
                    cfg_reg.flute_half_height <= cfg_wdata[4:0];
                end
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // Front: accept the cell, sum moments, classify wall and edge cases
    ldc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_data    (s_axis_tdata),
        .q_status  (q_stat),
        .push      (front_push),
        .push_data (front_data)
    );

    // Queue: decouple a stalled back end from the input side
    ldc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_push),
        .push_data (front_data),
        .pop       (back_stat.pop),
        .head      (q_head),
        .status    (q_stat)
    );

    // Back: equilibrium, relaxation, bounce-back, output register
    ldc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .head      (q_head),
        .q_status  (q_stat),
        .stat      (back_stat),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata)
    );

    // Front must hold its item while the queue is full
    `LDC_ASSERT_IMPL(a_queue_no_overflow, q_stat.full, !front_push, "push into full queue")
    // Back may only draw from a non-empty queue
    `LDC_ASSERT_IMPL(a_queue_no_underflow, q_stat.empty, !back_stat.pop, "pop from empty queue")
    // A pushed item is in the queue on the next cycle
    `LDC_ASSERT_NEXT(a_push_lands, front_push, !q_stat.empty, "pushed item not held")
    // A new result only ever comes from the last back stage
    `LDC_ASSERT_IMPL(a_out_from_tail, $rose(m_axis_tvalid), $past(back_stat.tail_valid),
                     "result without source")

endmodule

`default_nettype wire

### bench/tb_lattice_d2q5_cell_collision.sv
// ----------------------------------------------------------------------------
// tb_lattice_d2q5_cell_collision
// Self-checking bench for the D2Q5 cell collision block. Cells are streamed in
// with random gaps and the output is back-pressured at random. Each accepted
// cell is run through a 64-bit predictor of the collision and the bounce-back
// rules, and every relaxed cell that comes out is compared field by field. The
// register set is reloaded between phases, extremes and masked writes among
// them.
// ----------------------------------------------------------------------------
module tb_lattice_d2q5_cell_collision;

    import ldc_pkg::*;

    localparam longint Q_UNIT          = 65536;
    localparam int     ITEMS_PER_PHASE = 210;
    localparam int     HOLD_OFF_CYCLES = 80;
    localparam int     TAIL_CYCLES     = 20;
    localparam q16_t   Q16_MAX         = 32'sh7FFFFFFF;
    localparam q16_t   Q16_MIN         = 32'sh80000000;

    // One input cell and one relaxed result, as the predictor sees them
    typedef struct {
        logic [8:0] x;
        logic [5:0] y;
        q16_t       rest;
        q16_t       east;
        q16_t       north;
        q16_t       west;
        q16_t       south;
    } lattice_cell_t;

    typedef struct {
        q16_t rest;
        q16_t east;
        q16_t north;
        q16_t west;
        q16_t south;
    } relaxed_cell_t;

    // One full load of the register set
    typedef struct {
        logic [CFG_DATA_W-1:0] relax_rate;
        logic [CFG_DATA_W-1:0] speed_term;
        logic [CFG_DATA_W-1:0] flute_gain;
        logic [CFG_DATA_W-1:0] edge_gain;
        logic [CFG_DATA_W-1:0] start_x;
        logic [CFG_DATA_W-1:0] length;
        logic [CFG_DATA_W-1:0] half_height;
    } reg_plan_t;

    // ------------------------------------------------------------------------
    // Collision predictor and store of expected relaxed cells
    // ------------------------------------------------------------------------
    class collision_scoreboard;
        longint        relax_rate;
        longint        speed_term;
        longint        flute_gain;
        longint        edge_gain;
        longint        flute_start;
        longint        flute_len;
        longint        half_height;
        relaxed_cell_t expected_q[$];
        int            checked;
        int            mismatches;

        function new();
            relax_rate  = RST_RELAX_RATE;
            speed_term  = RST_SPEED_TERM;
            flute_gain  = RST_FLUTE_GAIN;
            edge_gain   = RST_EDGE_GAIN;
            flute_start = RST_FLUTE_START;
            flute_len   = RST_FLUTE_LEN;
            half_height = RST_FLUTE_HH;
            checked     = 0;
            mismatches  = 0;
        endfunction

        // Registers keep only their own width of the written value
        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_RELAX_RATE:        relax_rate  = v[17:0];
                CFG_SPEED_TERM:        speed_term  = v[16:0];
                CFG_FLUTE_GAIN:        flute_gain  = v[16:0];
                CFG_EDGE_GAIN:         edge_gain   = v[16:0];
                CFG_FLUTE_START_X:     flute_start = v[8:0];
                CFG_FLUTE_LENGTH:      flute_len   = v[8:0];
                CFG_FLUTE_HALF_HEIGHT: half_height = v[4:0];
                default: ;
            endcase
        endfunction

        // floor((n + d/2) / d): round half up
        function longint round_div(longint n, longint d);
            longint x;
            longint q;
            x = n + d / 2;
            q = x / d;
            if (x % d != 0 && x < 0) q = q - 1;
            return q;
        endfunction

        function longint clamp_q16(longint v);
            if (v > longint'(Q16_MAX)) return longint'(Q16_MAX);
            if (v < longint'(Q16_MIN)) return longint'(Q16_MIN);
            return v;
        endfunction

        function longint relax_toward(longint f, longint q);
            return clamp_q16(f + round_div(relax_rate * (q - f), Q_UNIT));
        endfunction

        function longint scale_by(longint g, longint f);
            return clamp_q16(round_div(g * f, Q_UNIT));
        endfunction

        function longint moving_equilibrium(longint rho, longint j);
            return clamp_q16(round_div(speed_term * rho + 3 * Q_UNIT * j, 6 * Q_UNIT));
        endfunction

        function void note_cell(lattice_cell_t c);
            longint        x, y, f0, fe, fn, fw, fs;
            longint        rho, jx, jy, aux, lo, hi;
            relaxed_cell_t r;
            x   = c.x;
            y   = c.y;
            f0  = c.rest;
            fe  = c.east;
            fn  = c.north;
            fw  = c.west;
            fs  = c.south;
            rho = clamp_q16(f0 + fe + fn + fw + fs);
            jx  = clamp_q16(fe - fw);
            jy  = clamp_q16(fn - fs);
            aux = Q_UNIT - round_div(2 * speed_term, 3);
            lo  = GRID_H / 2 - half_height;
            hi  = GRID_H / 2 + half_height;

            r.rest = q16_t'(relax_toward(f0, clamp_q16(round_div(rho * aux, Q_UNIT))));

            // x-pair: the flute's closed end takes priority over the edge columns
            if (x == flute_start && y >= lo && y <= hi) begin
                r.east = q16_t'(scale_by(flute_gain, fw));
                r.west = q16_t'(scale_by(flute_gain, fe));
            end else if (x == EDGE_COL_LO || x == EDGE_COL_HI) begin
                r.east = q16_t'(scale_by(edge_gain, fw));
                r.west = q16_t'(scale_by(edge_gain, fe));
            end else begin
                r.east = q16_t'(relax_toward(fe, moving_equilibrium(rho, jx)));
                r.west = q16_t'(relax_toward(fw, moving_equilibrium(rho, -jx)));
            end

            // y-pair: the bore walls take priority over the edge rows
            if ((y == lo || y == hi) && x >= flute_start && x <= flute_start + flute_len) begin
                r.north = q16_t'(scale_by(flute_gain, fs));
                r.south = q16_t'(scale_by(flute_gain, fn));
            end else if (y == EDGE_ROW_LO || y == EDGE_ROW_HI) begin
                r.north = q16_t'(scale_by(edge_gain, fs));
                r.south = q16_t'(scale_by(edge_gain, fn));
            end else begin
                r.north = q16_t'(relax_toward(fn, moving_equilibrium(rho, jy)));
                r.south = q16_t'(relax_toward(fs, moving_equilibrium(rho, -jy)));
            end

            expected_q.push_back(r);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void compare_field(string name, q16_t want, q16_t got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [M_DATA_W-1:0] d);
            relaxed_cell_t want;
            checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t: relaxed cell expected none got %h", $time, d);
                return;
            end
            want = expected_q.pop_front();
            compare_field("new_rest",  want.rest,  d[31:0]);
            compare_field("new_east",  want.east,  d[63:32]);
            compare_field("new_north", want.north, d[95:64]);
            compare_field("new_west",  want.west,  d[127:96]);
            compare_field("new_south", want.south, d[159:128]);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and bench state
    // ------------------------------------------------------------------------
    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    collision_scoreboard sb;
    bit tx_idle        = 1'b1;  // sender draws gaps between cells
    bit rx_idle        = 1'b1;  // receiver draws stalls between cells
    int rx_hold_cycles = 0;     // one-off long stall, taken up by the receiver
    int cells_sent     = 0;
    int settings_loaded = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    lattice_d2q5_cell_collision dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Half of the draws give no wait at all, so back-to-back runs stay common
    function automatic int draw_wait();
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 18);
    endfunction

    // Plausible distribution: -1.0 up to 4.0
    function automatic q16_t small_dist();
        return q16_t'(int'($urandom_range(0, 327680)) - 65536);
    endfunction

    // Mostly plausible values, then raw 32-bit patterns and the rails
    function automatic q16_t random_dist();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) return small_dist();
        if (pick < 9) return q16_t'($urandom);
        case ($urandom_range(0, 2))
            0:       return Q16_MAX;
            1:       return Q16_MIN;
            default: return '0;
        endcase
    endfunction

    function automatic lattice_cell_t quiet_cell(int x, int y);
        lattice_cell_t c;
        c.x     = 9'(x);
        c.y     = 6'(y);
        c.rest  = small_dist();
        c.east  = small_dist();
        c.north = small_dist();
        c.west  = small_dist();
        c.south = small_dist();
        return c;
    endfunction

    // Steer coordinates onto and just beside the walls and edges of the
    // current setting, the rest of the time anywhere on the grid
    function automatic lattice_cell_t random_cell();
        lattice_cell_t c;
        longint        sx, ln, hh, mid;
        sx  = sb.flute_start;
        ln  = sb.flute_len;
        hh  = sb.half_height;
        mid = GRID_H / 2;
        case ($urandom_range(0, 7))
            0:       c.x = 9'(sx);
            1:       c.x = 9'(EDGE_COL_LO);
            2:       c.x = 9'(EDGE_COL_HI);
            3:       c.x = 9'(sx + ln);
            4:       c.x = 9'(sx - 1);
            5:       c.x = 9'(sx + ln + 1);
            default: c.x = 9'($urandom_range(0, GRID_W - 1));
        endcase
        case ($urandom_range(0, 7))
            0:       c.y = 6'(mid - hh);
            1:       c.y = 6'(mid + hh);
            2:       c.y = 6'(EDGE_ROW_LO);
            3:       c.y = 6'(EDGE_ROW_HI);
            4:       c.y = 6'(mid - hh - 1);
            5:       c.y = 6'(mid + hh + 1);
            default: c.y = 6'($urandom_range(0, GRID_H - 1));
        endcase
        c.rest  = random_dist();
        c.east  = random_dist();
        c.north = random_dist();
        c.west  = random_dist();
        c.south = random_dist();
        return c;
    endfunction

    // Offer one cell after an optional gap; hold it until the block takes it
    task automatic send_cell(input lattice_cell_t c);
        int gap;
        gap = tx_idle ? draw_wait() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, c.south, c.west, c.north, c.east, c.rest, c.y, c.x};
        do @(posedge aclk); while (s_axis_tready !== 1'b1);
        sb.note_cell(c);
        cells_sent++;
    endtask

    // Drop valid and wait until every predicted cell has come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Write enable stays high across a burst and drops after the last write
    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.write_reg(idx, value);
    endtask

    task automatic load_settings(input reg_plan_t p);
        write_register(CFG_RELAX_RATE,        p.relax_rate);
        write_register(CFG_SPEED_TERM,        p.speed_term);
        write_register(CFG_FLUTE_GAIN,        p.flute_gain);
        write_register(CFG_EDGE_GAIN,         p.edge_gain);
        write_register(CFG_FLUTE_START_X,     p.start_x);
        write_register(CFG_FLUTE_LENGTH,      p.length);
        write_register(CFG_FLUTE_HALF_HEIGHT, p.half_height);
        cfg_wr_en <= 1'b0;
        settings_loaded++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls per item, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = rx_idle ? draw_wait() : 0;
            if (rx_hold_cycles > 0) begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (m_axis_tvalid !== 1'b1);
            sb.check_result(m_axis_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        lattice_cell_t c;
        reg_plan_t     plan;
        int            probe_x [18];
        int            probe_y [18];

        // Walls and edges under the reset setting: flute end column at 20,
        // bore rows 25 and 39, walls running to column 350
        probe_x = '{20, 20, 20, 20, 20, 1, 511, 100, 100, 1, 511, 350, 351, 19, 0, 511, 20, 100};
        probe_y = '{32, 25, 39, 24, 40, 32, 32, 1, 62, 1, 62, 25, 39, 25, 63, 63, 1, 32};

        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Zero cell and the rails of every distribution
        c = quiet_cell(0, 0);
        c.rest = '0; c.east = '0; c.north = '0; c.west = '0; c.south = '0;
        send_cell(c);
        c = quiet_cell(5, 10);
        c.rest = Q16_MAX; c.east = Q16_MAX; c.north = Q16_MAX; c.west = Q16_MAX; c.south = Q16_MAX;
        send_cell(c);
        c.rest = Q16_MIN; c.east = Q16_MIN; c.north = Q16_MIN; c.west = Q16_MIN; c.south = Q16_MIN;
        send_cell(c);
        // Opposed rails saturate both momenta
        c = quiet_cell(300, 12);
        c.east = Q16_MAX; c.west = Q16_MIN; c.north = Q16_MIN; c.south = Q16_MAX;
        send_cell(c);

        for (int i = 0; i < 18; i++) send_cell(quiet_cell(probe_x[i], probe_y[i]));

        // Phase 0 keeps the reset values; the others reload every register
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                1: plan = '{18'd65536, 18'd49152, 18'd65536, 18'd65536, 18'd100, 18'd50, 18'd3};
                2: plan = '{18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0};
                3: plan = '{18'd131072, 18'd98304, 18'd65536, 18'd65536, 18'd511, 18'd511, 18'd31};
                // all ones: each register keeps only its own width
                4: plan = '{18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF,
                            18'h3FFFF};
                5: begin
                    plan.relax_rate  = 18'($urandom_range(0, 131072));
                    plan.speed_term  = 18'($urandom_range(0, 98304));
                    plan.flute_gain  = 18'($urandom_range(0, 65536));
                    plan.edge_gain   = 18'($urandom_range(0, 65536));
                    plan.start_x     = 18'($urandom_range(0, 511));
                    plan.length      = 18'($urandom_range(0, 511));
                    plan.half_height = 18'($urandom_range(0, 31));
                end
                6: begin
                    plan.relax_rate  = 18'($urandom);
                    plan.speed_term  = 18'($urandom);
                    plan.flute_gain  = 18'($urandom);
                    plan.edge_gain   = 18'($urandom);
                    plan.start_x     = 18'($urandom);
                    plan.length      = 18'($urandom);
                    plan.half_height = 18'($urandom);
                end
                7: plan = '{RST_RELAX_RATE, RST_SPEED_TERM, RST_FLUTE_GAIN, RST_EDGE_GAIN,
                            RST_FLUTE_START, RST_FLUTE_LEN, RST_FLUTE_HH};
                default: ;
            endcase
            if (phase > 0) load_settings(plan);

            // Phase 1 runs flat out on both sides with one long output hold,
            // so the queue fills and the input stalls; 2 and 3 idle one side
            tx_idle = (phase != 1 && phase != 3);
            rx_idle = (phase != 1 && phase != 2);
            if (phase == 1) rx_hold_cycles = HOLD_OFF_CYCLES;

            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // hold the input mid-phase until the pipeline is empty
                if (phase == 4 && i == ITEMS_PER_PHASE / 2) drain_results();
                send_cell(random_cell());
            end
            drain_results();
        end

        // Let anything stray surface before the verdict
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d cells over the reset setting and %0d reloaded settings,",
                 cells_sent, settings_loaded);
        $display("with random gaps, back-pressure and a full-queue stall: %0d compared, %0d bad",
                 sb.checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run
    initial begin : watchdog
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
